// ----- rtl/core/ucv_pkg.sv -----
// Package for the UDP checksum verifier: payload structs, status codes,
// queue entry type and one's complement helpers. No dependencies.
package ucv_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam logic [15:0] ProtoUdp   = 16'h0011;

  typedef enum logic [1:0] {
    ST_UNVERIFIED = 2'd0,
    ST_GOOD       = 2'd1,
    ST_BAD        = 2'd2,
    ST_TRUNCATED  = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] word;
    logic        first;
    logic        last;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] computed_sum;
    logic [15:0] received_sum;
    logic [15:0] datagram_length;
  } result_t;

  // One classified word handed from front to back
  typedef struct packed {
    logic [15:0] addend;
    logic        first;
    logic        last;
    logic        truncated;
    logic [15:0] received_sum;
    logic [15:0] datagram_length;
  } entry_t;

  // Fold a plain sum of a few 16-bit terms into an end-around-carry sum
  function automatic logic [15:0] oc_fold(input logic [19:0] s);
    logic [16:0] t;
    logic [16:0] u;
    t = {1'b0, s[15:0]} + {13'd0, s[19:16]};
    u = {1'b0, t[15:0]} + {16'd0, t[16]};
    return u[15:0];
  endfunction

  // Contribution of datagram word idx for datagram length len
  function automatic logic [15:0] word_part(input logic [15:0] idx,
                                            input logic [15:0] w,
                                            input logic [15:0] len);
    logic [15:0] half;
    half = {1'b0, len[15:1]};
    if (idx < half) begin
      return (idx == 16'd3) ? 16'd0 : w;
    end else if (len[0] && idx == half) begin
      return {w[15:8], 8'h00};
    end
    return 16'd0;
  endfunction

endpackage

// ----- rtl/core/ucv_front.sv -----
// Front end: tracks header position, length and checksum of the current
// datagram and reduces each word to one addend. Uses ucv_pkg.
module ucv_front
  import ucv_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  item_t  item,
  input  logic   push,
  output entry_t entry
);

  logic [15:0] word_index;
  logic [15:0] length_seen;
  logic [15:0] checksum_seen;
  logic [15:0] head0;
  logic [15:0] head1;

  logic [15:0] idx_eff, len_eff, chk_eff, h0_eff, h1_eff;
  logic [15:0] len_new, chk_new, count;
  logic [16:0] need;
  logic [19:0] acc;

  // A first mark starts from a clean frame state
  always_comb begin
    idx_eff = item.first ? 16'd0 : word_index;
    len_eff = item.first ? 16'd0 : length_seen;
    chk_eff = item.first ? 16'd0 : checksum_seen;
    h0_eff  = item.first ? 16'd0 : head0;
    h1_eff  = item.first ? 16'd0 : head1;
  end

  // Addend of this word: addresses, pseudo-header and held words
  always_comb begin
    acc = 20'd0;
    if (item.first) begin
      acc = {4'd0, item.src_addr[31:16]} + {4'd0, item.src_addr[15:0]}
          + {4'd0, item.dst_addr[31:16]} + {4'd0, item.dst_addr[15:0]};
    end
    case (idx_eff)
      16'd0, 16'd1: begin
      end
      16'd2: begin
        acc = acc + {4'd0, ProtoUdp} + {4'd0, item.word}
            + {4'd0, word_part(16'd0, h0_eff, item.word)}
            + {4'd0, word_part(16'd1, h1_eff, item.word)}
            + {4'd0, word_part(16'd2, item.word, item.word)};
      end
      default: begin
        acc = acc + {4'd0, word_part(idx_eff, item.word, len_eff)};
      end
    endcase
  end

  // Header latches, saturating count and truncation check
  always_comb begin
    len_new = (idx_eff == 16'd2) ? item.word : len_eff;
    chk_new = (idx_eff == 16'd3) ? item.word : chk_eff;
    count   = (idx_eff != 16'hffff) ? idx_eff + 16'd1 : idx_eff;
    need    = ({1'b0, len_new} + 17'd1) >> 1;

    entry.addend          = oc_fold(acc);
    entry.first           = item.first;
    entry.last            = item.last;
    entry.truncated       = (count < 16'd4) || ({1'b0, count} < need);
    entry.received_sum    = chk_new;
    entry.datagram_length = len_new;
  end

  // Frame state, cleared after the last word
  always_ff @(posedge clk) begin
    if (rst) begin
      word_index    <= '0;
      length_seen   <= '0;
      checksum_seen <= '0;
      head0         <= '0;
      head1         <= '0;
    end else if (push) begin
      if (item.last) begin
        word_index    <= '0;
        length_seen   <= '0;
        checksum_seen <= '0;
        head0         <= '0;
        head1         <= '0;
      end else begin
        word_index    <= count;
        length_seen   <= len_new;
        checksum_seen <= chk_new;
        head0         <= (idx_eff == 16'd0) ? item.word : h0_eff;
        head1         <= (idx_eff == 16'd1) ? item.word : h1_eff;
      end
    end
  end

endmodule

// ----- rtl/core/ucv_queue.sv -----
// Short FIFO of classified words between front and back.
// Uses ucv_pkg for the entry type.
module ucv_queue
  import ucv_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   valid,
  output entry_t head
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  entry_t          mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == Full);
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  // Storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/ucv_back.sv -----
// Back end: accumulates addends into the running sum and registers the
// result on the last word of a datagram. Uses ucv_pkg.
module ucv_back
  import ucv_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    validate_enable,
  input  logic    q_valid,
  input  entry_t  q_head,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic [15:0] running_sum;
  logic [15:0] sum_next;
  logic [15:0] computed;
  status_t     status_next;

  // Last words wait for a free output register
  assign pop = q_valid && (!q_head.last || !result_valid || result_ready);

  always_comb begin
    sum_next = oc_fold({4'd0, q_head.first ? 16'd0 : running_sum}
                       + {4'd0, q_head.addend});
    computed = ~sum_next;
    if (!validate_enable) begin
      status_next = ST_UNVERIFIED;
    end else if (q_head.truncated) begin
      status_next = ST_TRUNCATED;
    end else if (computed == q_head.received_sum) begin
      status_next = ST_GOOD;
    end else begin
      status_next = ST_BAD;
    end
  end

  // Running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (pop) begin
      running_sum <= q_head.last ? 16'd0 : sum_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop && q_head.last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_head.last) begin
      result.status          <= status_next;
      result.computed_sum    <= computed;
      result.received_sum    <= q_head.received_sum;
      result.datagram_length <= q_head.datagram_length;
    end
  end

endmodule

// ----- rtl/core/udp_checksum_verifier.sv -----
// UDP checksum verifier for a stream of 16-bit datagram words.
// With the queue empty and the output free, a last word enters the queue at its
// transfer edge and its result is registered in the output register on the next
// edge. Throughput: one word per cycle while item_ready is high, as the back
// end accumulates one addend per popped word; a stalled result lets the queue
// fill with Depth words (two by default) before item_ready drops.
// Reset (rst, synchronous): clears frame state, queue and output valid;
// validate_enable returns to 1.
module udp_checksum_verifier
  import ucv_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_write,
  input  logic    cfg_data,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic   validate_enable;
  logic   push, full, pop, q_valid;
  entry_t entry, q_head;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      validate_enable <= 1'b1;
    end else if (cfg_write) begin
      validate_enable <= cfg_data;
    end
  end

  assign item_ready = !full;
  assign push       = item_valid && item_ready;

  ucv_front u_front (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .push  (push),
    .entry (entry)
  );

  ucv_queue #(.Depth(Depth)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .full      (full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  ucv_back u_back (
    .clk             (clk),
    .rst             (rst),
    .validate_enable (validate_enable),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .pop             (pop),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result          (result)
  );

endmodule

// ----- rtl/core/ucv_checker.sv -----
// Port-level assertions for udp_checksum_verifier, attached by bind.
// Uses ucv_pkg for types and status codes.
module ucv_port_props
  import ucv_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    cfg_write,
  input logic    cfg_data,
  input logic    item_valid,
  input logic    item_ready,
  input item_t   item,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // A stalled result transfer keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Reset leaves no result pending
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // Good status only when the sums agree
  a_good: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_GOOD
      |-> result.computed_sum == result.received_sum)
    else $error("good status with mismatched sums");

  // Bad status only when the sums differ
  a_bad: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_BAD
      |-> result.computed_sum != result.received_sum)
    else $error("bad status with matching sums");

endmodule

bind udp_checksum_verifier ucv_port_props u_port_props (.*);
